[rtl/color_marker_run_detector_macros.svh]
// ----------------------------------------------------------------------------
// Color marker run detector assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef COLOR_MARKER_RUN_DETECTOR_MACROS_SVH
`define COLOR_MARKER_RUN_DETECTOR_MACROS_SVH

// same-cycle implication, masked while reset is asserted
`define CMRD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cmrd check failed");

// next-cycle implication, active during reset as well
`define CMRD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("cmrd check failed");

`endif

[rtl/cmrd_pkg.sv]
// ----------------------------------------------------------------------------
// Color marker run detector package
// Types, register codes and pixel classification functions.
// ----------------------------------------------------------------------------
package cmrd_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_LINE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BLUE_START   = 2'd2;
    localparam logic [1:0] REG_RED_START    = 2'd3;

    localparam logic [11:0] LINE_WIDTH_RST   = 12'd1920;
    localparam logic [11:0] FRAME_HEIGHT_RST = 12'd1080;

    // run width scale applied to the dark sample count
    localparam logic [15:0] WIDTH_SCALE = 16'd25;

    typedef struct packed {
        logic [10:0] x;
        logic [10:0] y;
        logic [15:0] width;
    } t_best;

    // classified pixel handed from front to back
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        cur_dark;
        logic        cur_bluish;
        logic        cur_reddish;
        logic        sampled;
        logic        line_start;
        logic        frame_start;
        logic        frame_last;
        logic [10:0] col;
        logic [10:0] row;
    } t_job;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_last;
        t_best      blue_best;
        t_best      red_best;
    } t_result;

    // signed difference of two components
    function automatic logic signed [9:0] diff(input logic [7:0] a, input logic [7:0] b);
        diff = $signed({2'b00, a}) - $signed({2'b00, b});
    endfunction

    function automatic logic is_dark(input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b);
        is_dark = (r < 8'd40) && (g < 8'd40) && (b < 8'd40);
    endfunction

    function automatic logic is_bluish(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
        logic signed [9:0] br;
        logic signed [9:0] bg;
        br = diff(b, r);
        bg = diff(b, g);
        is_bluish = (b > 8'd100) && (br > 10'sd80) && (br < 10'sd150)
                    && (bg < 10'sd62) && (bg > 10'sd35);
    endfunction

    function automatic logic is_reddish(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        logic signed [9:0] rb;
        logic signed [9:0] rg;
        rb = diff(r, b);
        rg = diff(r, g);
        is_reddish = (r > 8'd135) && (rb < 10'sd155) && (rb > 10'sd80)
                     && (rg < 10'sd155) && (rg > 10'sd80);
    endfunction

endpackage

[rtl/color_marker_run_detector.sv]
// ----------------------------------------------------------------------------
// Color marker run detector
// Finds the widest blue and red marker runs in a raster pixel stream.
// ----------------------------------------------------------------------------
// A pushed pixel is stored in the job queue, then the back end's result for it is stored in the result queue.
// Throughput: one pixel per clock while the result queue has room, set by the run state update in the back end.
// Two-entry queues between front and back and on the result side absorb stalls.
// Reset (synchronous, active low) empties both queues, clears position and run state,
// clears the best records and loads configuration registers with their defaults.
module color_marker_run_detector #(
    parameter int MAX_LINE    = 2048,
    parameter int MAX_ROWS    = 2048,
    parameter int SAMPLE_STEP = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel input queue side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_red,
    input  logic [7:0]  i_in_green,
    input  logic [7:0]  i_in_blue,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_pix_red,
    output logic [7:0]  o_pix_green,
    output logic [7:0]  o_pix_blue,
    output logic        o_frame_last,
    output logic [10:0] o_blue_best_x,
    output logic [10:0] o_blue_best_y,
    output logic [15:0] o_blue_best_width,
    output logic [10:0] o_red_best_x,
    output logic [10:0] o_red_best_y,
    output logic [15:0] o_red_best_width,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cmrd_pkg::*;

    logic [11:0] r_line_width;
    logic [11:0] r_frame_height;
    logic [15:0] r_blue_start;
    logic [15:0] r_red_start;
    logic        cfg_wr;
    logic [1:0]  reg_idx;

    t_job    front_job;
    t_job    back_job;
    t_result back_result;
    t_result out_result;
    logic    accept;
    logic    job_empty;
    logic    res_full;
    logic    advance;

    // configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= LINE_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_blue_start   <= '0;
            r_red_start    <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_LINE_WIDTH:   r_line_width   <= pwdata[11:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[11:0];
                REG_BLUE_START:   r_blue_start   <= pwdata[15:0];
                REG_RED_START:    r_red_start    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            REG_LINE_WIDTH:   prdata = {20'd0, r_line_width};
            REG_FRAME_HEIGHT: prdata = {20'd0, r_frame_height};
            REG_BLUE_START:   prdata = {16'd0, r_blue_start};
            REG_RED_START:    prdata = {16'd0, r_red_start};
            default:          prdata = '0;
        endcase
    end

    // front: position and classification
    assign accept = push && !full;

    cmrd_front #(
        .MAX_LINE    (MAX_LINE),
        .MAX_ROWS    (MAX_ROWS),
        .SAMPLE_STEP (SAMPLE_STEP)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_red          (i_in_red),
        .i_green        (i_in_green),
        .i_blue         (i_in_blue),
        .i_line_width   (r_line_width),
        .i_frame_height (r_frame_height),
        .o_job          (front_job)
    );

    // queue between front and back
    cmrd_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (2)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .i_pop   (advance),
        .o_data  (back_job),
        .o_full  (full),
        .o_empty (job_empty)
    );

    // back: run tracking
    assign advance = !job_empty && !res_full;

    cmrd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_job        (back_job),
        .i_blue_start (r_blue_start),
        .i_red_start  (r_red_start),
        .o_result     (back_result)
    );

    // result queue
    cmrd_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (advance),
        .i_data  (back_result),
        .i_pop   (pop),
        .o_data  (out_result),
        .o_full  (res_full),
        .o_empty (empty)
    );

    assign o_pix_red         = out_result.red;
    assign o_pix_green       = out_result.green;
    assign o_pix_blue        = out_result.blue;
    assign o_frame_last      = out_result.frame_last;
    assign o_blue_best_x     = out_result.blue_best.x;
    assign o_blue_best_y     = out_result.blue_best.y;
    assign o_blue_best_width = out_result.blue_best.width;
    assign o_red_best_x      = out_result.red_best.x;
    assign o_red_best_y      = out_result.red_best.y;
    assign o_red_best_width  = out_result.red_best.width;

endmodule

[rtl/cmrd_fifo.sv]
// ----------------------------------------------------------------------------
// Small register queue
// Generic first-in first-out queue with combinational head output.
// ----------------------------------------------------------------------------
module cmrd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

[rtl/cmrd_front.sv]
// ----------------------------------------------------------------------------
// Detector front end
// Tracks raster position and sample phase, classifies each accepted pixel.
// ----------------------------------------------------------------------------
module cmrd_front #(
    parameter int MAX_LINE    = 2048,
    parameter int MAX_ROWS    = 2048,
    parameter int SAMPLE_STEP = 25
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_red,
    input  logic [7:0]      i_green,
    input  logic [7:0]      i_blue,
    input  logic [11:0]     i_line_width,
    input  logic [11:0]     i_frame_height,
    output cmrd_pkg::t_job  o_job
);
    import cmrd_pkg::*;

    localparam int CW  = $clog2(MAX_LINE);
    localparam int LW  = $clog2(MAX_LINE + 1);
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int HW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS + 1) : 2;
    localparam int PW  = (SAMPLE_STEP > 1) ? $clog2(SAMPLE_STEP) : 1;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [PW-1:0] r_phase;
    logic [LW-1:0] line_w;
    logic [HW-1:0] frame_h;
    logic          row_end;
    logic          frame_end;
    logic [PW:0]   phase_inc;

    // effective dimensions: zero acts as one, saturate at the maximum
    always_comb begin
        if (i_line_width == '0) begin
            line_w = LW'(1);
        end else if (13'(i_line_width) > 13'(MAX_LINE)) begin
            line_w = LW'(MAX_LINE);
        end else begin
            line_w = LW'(i_line_width);
        end
        if (i_frame_height == '0) begin
            frame_h = HW'(1);
        end else if (13'(i_frame_height) > 13'(MAX_ROWS)) begin
            frame_h = HW'(MAX_ROWS);
        end else begin
            frame_h = HW'(i_frame_height);
        end
    end

    assign row_end   = (LW'(r_col) + LW'(1)) >= line_w;
    assign frame_end = row_end && ((HW'(r_row) + HW'(1)) >= frame_h);
    assign phase_inc = {1'b0, r_phase} + (PW + 1)'(1);

    // classification of the current pixel
    always_comb begin
        o_job.red         = i_red;
        o_job.green       = i_green;
        o_job.blue        = i_blue;
        o_job.cur_dark    = is_dark(i_red, i_green, i_blue);
        o_job.cur_bluish  = is_bluish(i_red, i_green, i_blue);
        o_job.cur_reddish = is_reddish(i_red, i_green, i_blue);
        o_job.line_start  = (r_col == '0);
        o_job.frame_start = (r_col == '0) && (r_row == '0);
        o_job.sampled     = (r_col == '0) || (r_phase == '0);
        o_job.frame_last  = frame_end;
        o_job.col         = 11'(r_col);
        o_job.row         = 11'(r_row);
    end

    // raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_phase <= '0;
        end else if (i_accept) begin
            if (row_end) begin
                r_col   <= '0;
                r_phase <= '0;
                r_row   <= frame_end ? '0 : r_row + RW'(1);
            end else begin
                r_col   <= r_col + CW'(1);
                r_phase <= (phase_inc >= (PW + 1)'(SAMPLE_STEP)) ? '0 : r_phase + PW'(1);
            end
        end
    end

endmodule

[rtl/cmrd_back.sv]
// ----------------------------------------------------------------------------
// Detector back end
// Run state machine, best marker records and pixel painting.
// ----------------------------------------------------------------------------
module cmrd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  cmrd_pkg::t_job    i_job,
    input  logic [15:0]       i_blue_start,
    input  logic [15:0]       i_red_start,
    output cmrd_pkg::t_result o_result
);
    import cmrd_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_BLUE,
        MODE_RED
    } t_mode;

    t_mode       r_mode,   n_mode;
    logic [15:0] r_count,  n_count;
    logic        r_pdark,  n_pdark;
    logic        r_pblue,  n_pblue;
    logic        r_pred,   n_pred;
    t_best       r_bbest,  n_bbest;
    t_best       r_rbest,  n_rbest;
    logic        paint;
    logic        match;
    logic [15:0] cur_width;
    logic [15:0] scaled;

    assign scaled = 16'(r_count * WIDTH_SCALE);

    // next state for one pixel
    always_comb begin
        n_mode    = r_mode;
        n_count   = r_count;
        n_pdark   = r_pdark;
        n_pblue   = r_pblue;
        n_pred    = r_pred;
        n_bbest   = r_bbest;
        n_rbest   = r_rbest;
        paint     = 1'b0;
        match     = 1'b0;
        cur_width = '0;
        if (i_job.line_start) begin
            if (i_job.frame_start) begin
                // previous sample restarts as black
                n_pdark = 1'b1;
                n_pblue = 1'b0;
                n_pred  = 1'b0;
                n_bbest = '{x: '0, y: '0, width: i_blue_start};
                n_rbest = '{x: '0, y: '0, width: i_red_start};
            end
            n_mode  = MODE_IDLE;
            n_count = '0;
        end
        if (i_job.sampled) begin
            case (n_mode)
                MODE_BLUE, MODE_RED: begin
                    match     = (n_mode == MODE_BLUE) ? i_job.cur_bluish : i_job.cur_reddish;
                    cur_width = (n_mode == MODE_BLUE) ? n_bbest.width : n_rbest.width;
                    if (match && n_pdark) begin
                        if (n_count > cur_width) begin
                            // line start clears the count, so r_count is n_count here
                            if (n_mode == MODE_BLUE) begin
                                n_bbest = '{x: i_job.col, y: i_job.row, width: scaled};
                            end else begin
                                n_rbest = '{x: i_job.col, y: i_job.row, width: scaled};
                            end
                        end
                    end else if (i_job.cur_dark && n_pdark) begin
                        n_count = n_count + 16'd1;
                        paint   = 1'b1;
                    end else begin
                        n_mode = MODE_IDLE;
                    end
                end
                default: begin
                    n_mode = MODE_IDLE;
                    if (i_job.cur_dark) begin
                        if (n_pblue) begin
                            n_mode  = MODE_BLUE;
                            n_count = '0;
                        end else if (n_pred) begin
                            n_mode  = MODE_RED;
                            n_count = '0;
                        end
                    end
                end
            endcase
            n_pdark = i_job.cur_dark;
            n_pblue = i_job.cur_bluish;
            n_pred  = i_job.cur_reddish;
        end
    end

    // result for this pixel
    always_comb begin
        o_result.red        = paint ? 8'hFF : i_job.red;
        o_result.green      = paint ? 8'hFF : i_job.green;
        o_result.blue       = paint ? 8'hFF : i_job.blue;
        o_result.frame_last = i_job.frame_last;
        o_result.blue_best  = n_bbest;
        o_result.red_best   = n_rbest;
    end

    // run state and best records
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_count <= '0;
            r_pdark <= 1'b1;
            r_pblue <= 1'b0;
            r_pred  <= 1'b0;
            r_bbest <= '0;
            r_rbest <= '0;
        end else if (i_advance) begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_pdark <= n_pdark;
            r_pblue <= n_pblue;
            r_pred  <= n_pred;
            r_bbest <= n_bbest;
            r_rbest <= n_rbest;
        end
    end

endmodule

[rtl/cmrd_checker.sv]
// ----------------------------------------------------------------------------
// Detector port checker
// Watches queue and configuration ports of the top level over time.
// ----------------------------------------------------------------------------
`include "color_marker_run_detector_macros.svh"

module cmrd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);
    import cmrd_pkg::*;

    logic        lw_rd;
    logic [31:0] rb_value;
    logic        r_lw_wr;
    logic [11:0] r_lw_data;

    // read of the line width register in this cycle
    assign lw_rd    = psel && !pwrite && (paddr[3:2] == REG_LINE_WIDTH);
    assign rb_value = {20'd0, r_lw_data};

    // last cycle's line width write transfer and its data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw_wr   <= 1'b0;
            r_lw_data <= '0;
        end else begin
            r_lw_wr   <= psel && penable && pwrite && (paddr[3:2] == REG_LINE_WIDTH);
            r_lw_data <= pwdata[11:0];
        end
    end

    // reset leaves no result waiting
    `CMRD_ASSERT_NEXT(a_reset_empty, !i_rst_n, empty)

    // input side can only back up while a result is held
    `CMRD_ASSERT_IMPL(a_full_has_result, full, !empty)

    // line width readback after a write transfer
    `CMRD_ASSERT_IMPL(a_cfg_readback, r_lw_wr && lw_rd, prdata == rb_value)

endmodule

bind color_marker_run_detector cmrd_checker u_cmrd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .empty   (empty),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata)
);

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// Color marker run detector testbench
// Streams pixels through the detector under random push/pop gaps and checks
// every output pixel and best-marker record against an in-bench predictor.
// Covers corner pixels, dimension clamping, mid-frame register changes and
// scripted dark runs between blue or red edges at the sampled columns.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cmrd_pkg::*;

    localparam int LINE_MAX    = 2048;
    localparam int ROW_MAX     = 2048;
    localparam int SAMPLE_STEP = 25;
    localparam int IDLE_PCT    = 8;
    localparam int CALM_FROM   = 300;   // transfer counts with no random idling
    localparam int CALM_TO     = 420;
    localparam int HOLD_AT     = 120;   // result count where the receiver stalls
    localparam int HOLD_CYCLES = 80;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 10;

    // pixels whose differences only match when taken as unsigned bytes
    localparam logic [23:0] WRAP_BLUE = 24'hFA466E;
    localparam logic [23:0] WRAP_RED  = 24'h8CFAFA;

    // corner pixels, one per row, four rows per frame
    localparam logic [23:0] EDGE_PIXELS [0:17] = '{
        24'h000000, 24'hFFFFFF, 24'h000000, 24'h14466E, 24'h000000, 24'hC8505A,
        24'h272727, 24'h280000, 24'hFA466E, 24'h000000, 24'h8CFAFA, 24'h000000,
        24'h1E4B6E, 24'h00306E, 24'h880000, 24'hFF6464, 24'hFFAEAE, 24'h143C64
    };

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    typedef enum logic [1:0] {RUN_IDLE, RUN_BLUE, RUN_RED} t_run_color;
    typedef enum logic [1:0] {PX_DARK, PX_BLUE, PX_RED, PX_ANY} t_px_kind;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push    = 1'b0;
    logic        pop     = 1'b0;
    logic [7:0]  i_in_red   = '0;
    logic [7:0]  i_in_green = '0;
    logic [7:0]  i_in_blue  = '0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic        full, empty, pready;
    logic [31:0] prdata;
    logic [7:0]  o_pix_red, o_pix_green, o_pix_blue;
    logic        o_frame_last;
    logic [10:0] o_blue_best_x, o_blue_best_y, o_red_best_x, o_red_best_y;
    logic [15:0] o_blue_best_width, o_red_best_width;

    color_marker_run_detector dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_in_red(i_in_red), .i_in_green(i_in_green), .i_in_blue(i_in_blue),
        .empty(empty), .pop(pop),
        .o_pix_red(o_pix_red), .o_pix_green(o_pix_green), .o_pix_blue(o_pix_blue),
        .o_frame_last(o_frame_last),
        .o_blue_best_x(o_blue_best_x), .o_blue_best_y(o_blue_best_y),
        .o_blue_best_width(o_blue_best_width),
        .o_red_best_x(o_red_best_x), .o_red_best_y(o_red_best_y),
        .o_red_best_width(o_red_best_width),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor copy of the configuration and detector state
    logic [11:0] cfg_line_width   = LINE_WIDTH_RST;
    logic [11:0] cfg_frame_height = FRAME_HEIGHT_RST;
    logic [15:0] cfg_blue_start   = '0;
    logic [15:0] cfg_red_start    = '0;
    int          col_pos      = 0;
    int          row_pos      = 0;
    int          sample_phase = 0;
    t_run_color  run_color    = RUN_IDLE;
    logic [15:0] run_len      = '0;
    t_rgb        prev_sample  = '0;
    t_best       blue_rec     = '0;
    t_best       red_rec      = '0;

    t_rgb        pending_pixels[$];
    t_result     expected_pixels[$];
    t_px_kind    sample_plan[$];
    int          mismatch_count = 0;
    int          pixels_sent    = 0;
    int          pixels_checked = 0;
    int          hold_left      = 0;
    bit          hold_done      = 1'b0;
    int          stall_cycles   = 0;

    function automatic bit dark_px(input int r, input int g, input int b);
        return r < 40 && g < 40 && b < 40;
    endfunction

    function automatic bit bluish_px(input int r, input int g, input int b);
        return b > 100 && b - r > 80 && b - r < 150 && b - g > 35 && b - g < 62;
    endfunction

    function automatic bit reddish_px(input int r, input int g, input int b);
        return r > 135 && r - b > 80 && r - b < 155 && r - g > 80 && r - g < 155;
    endfunction

    function automatic int clamp_dim(input logic [11:0] v, input int maxv);
        if (v == 0) return 1;
        return (v > maxv) ? maxv : int'(v);
    endfunction

    // a better run replaces the record only when the count beats the stored width
    function automatic t_best improve_best(input t_best rec);
        t_best nb;
        nb = rec;
        if (run_len > rec.width) begin
            nb.x     = col_pos[10:0];
            nb.y     = row_pos[10:0];
            nb.width = run_len * WIDTH_SCALE;
        end
        return nb;
    endfunction

    // advance the detector state by one pixel and return the output it produces
    function automatic t_result detect_pixel(input t_rgb px);
        t_result res;
        int      w, h;
        bit      prev_dark, cur_dark, hit, row_end, frame_end;
        w = clamp_dim(cfg_line_width, LINE_MAX);
        h = clamp_dim(cfg_frame_height, ROW_MAX);
        res.red   = px.r;
        res.green = px.g;
        res.blue  = px.b;
        if (col_pos == 0) begin
            if (row_pos == 0) begin
                prev_sample = '0;
                blue_rec    = '{x: '0, y: '0, width: cfg_blue_start};
                red_rec     = '{x: '0, y: '0, width: cfg_red_start};
            end
            run_color    = RUN_IDLE;
            run_len      = '0;
            sample_phase = 0;
        end
        if (sample_phase == 0) begin
            prev_dark = dark_px(prev_sample.r, prev_sample.g, prev_sample.b);
            cur_dark  = dark_px(px.r, px.g, px.b);
            if (run_color == RUN_BLUE || run_color == RUN_RED) begin
                hit = (run_color == RUN_BLUE) ? bluish_px(px.r, px.g, px.b)
                                              : reddish_px(px.r, px.g, px.b);
                if (hit && prev_dark) begin
                    if (run_color == RUN_BLUE) blue_rec = improve_best(blue_rec);
                    else red_rec = improve_best(red_rec);
                end else if (cur_dark && prev_dark) begin
                    run_len   = run_len + 16'd1;
                    res.red   = 8'hFF;
                    res.green = 8'hFF;
                    res.blue  = 8'hFF;
                end else begin
                    run_color = RUN_IDLE;
                end
            end else begin
                run_color = RUN_IDLE;
                if (cur_dark) begin
                    if (bluish_px(prev_sample.r, prev_sample.g, prev_sample.b)) begin
                        run_color = RUN_BLUE;
                        run_len   = '0;
                    end else if (reddish_px(prev_sample.r, prev_sample.g, prev_sample.b)) begin
                        run_color = RUN_RED;
                        run_len   = '0;
                    end
                end
            end
            prev_sample = px;
        end
        row_end   = col_pos + 1 >= w;
        frame_end = row_end && row_pos + 1 >= h;
        res.frame_last = frame_end;
        res.blue_best  = blue_rec;
        res.red_best   = red_rec;
        if (row_end) begin
            col_pos      = 0;
            sample_phase = 0;
            row_pos      = frame_end ? 0 : row_pos + 1;
        end else begin
            col_pos      = col_pos + 1;
            sample_phase = (sample_phase + 1 >= SAMPLE_STEP) ? 0 : sample_phase + 1;
        end
        return res;
    endfunction

    // pixel of the requested class, with occasional near misses at the thresholds
    function automatic t_rgb make_pixel(input t_px_kind kind);
        t_rgb p;
        int   d1, d2;
        p = 24'($urandom);
        case (kind)
            PX_DARK: begin
                p.r = 8'($urandom_range(0, 39));
                p.g = 8'($urandom_range(0, 39));
                p.b = 8'($urandom_range(0, 39));
                if ($urandom_range(0, 9) == 0) p.g = 8'd40;
            end
            PX_BLUE: begin
                if ($urandom_range(0, 9) == 0) begin
                    p = WRAP_BLUE;
                end else begin
                    p.b = 8'($urandom_range(100, 255));
                    d1 = $urandom_range(81, (p.b < 149) ? p.b : 149);
                    d2 = $urandom_range(36, 61);
                    if ($urandom_range(0, 7) == 0) d1 = (p.b >= 150) ? 150 : 80;
                    if ($urandom_range(0, 7) == 0) d2 = $urandom_range(0, 1) ? 35 : 62;
                    p.r = 8'(p.b - d1);
                    p.g = 8'(p.b - d2);
                end
            end
            PX_RED: begin
                if ($urandom_range(0, 9) == 0) begin
                    p = WRAP_RED;
                end else begin
                    p.r = 8'($urandom_range(135, 255));
                    d1 = $urandom_range(81, (p.r < 154) ? p.r : 154);
                    d2 = $urandom_range(81, (p.r < 154) ? p.r : 154);
                    if ($urandom_range(0, 7) == 0) d1 = (p.r >= 155) ? 155 : 80;
                    if ($urandom_range(0, 7) == 0) d2 = (p.r >= 155) ? 155 : 80;
                    p.b = 8'(p.r - d1);
                    p.g = 8'(p.r - d2);
                end
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // wait until no pixel is queued, offered or outstanding
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_pixels.size() > 0 || push || expected_pixels.size() > 0);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LINE_WIDTH:   cfg_line_width   = value[11:0];
            REG_FRAME_HEIGHT: cfg_frame_height = value[11:0];
            REG_BLUE_START:   cfg_blue_start   = value[15:0];
            REG_RED_START:    cfg_red_start    = value[15:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int lw, input int fh, input int bs, input int rs);
        wait_drained();
        write_reg(REG_LINE_WIDTH, lw);
        write_reg(REG_FRAME_HEIGHT, fh);
        write_reg(REG_BLUE_START, bs);
        write_reg(REG_RED_START, rs);
    endtask

    // random pixels; the sampled columns mostly follow scripted edge/dark/edge runs, else random classes
    task automatic queue_pixels(input int count);
        int       col, w;
        t_px_kind kind, edge_kind;
        @(negedge i_clk);
        w   = clamp_dim(cfg_line_width, LINE_MAX);
        col = col_pos;
        repeat (count) begin
            kind = PX_ANY;
            if (col % SAMPLE_STEP == 0) begin
                if (sample_plan.size() == 0) begin
                    if ($urandom_range(0, 99) < 80) begin
                        edge_kind = $urandom_range(0, 1) ? PX_BLUE : PX_RED;
                        sample_plan.push_back(edge_kind);
                        repeat ($urandom_range(1, 4)) sample_plan.push_back(PX_DARK);
                        sample_plan.push_back(edge_kind);
                    end else begin
                        repeat ($urandom_range(1, 3))
                            sample_plan.push_back(t_px_kind'($urandom_range(0, 3)));
                    end
                end
                kind = sample_plan.pop_front();
            end
            pending_pixels.push_back(make_pixel(kind));
            col = (col + 1 >= w) ? 0 : col + 1;
        end
    endtask

    // input side: predict on each transfer, then offer the next pixel
    always @(posedge i_clk) begin : pixel_driver
        t_rgb px;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                expected_pixels.push_back(detect_pixel({i_in_red, i_in_green, i_in_blue}));
                pixels_sent++;
            end
            if (!push || !full) begin
                if (pending_pixels.size() > 0 &&
                    ((pixels_sent >= CALM_FROM && pixels_sent < CALM_TO) ||
                     $urandom_range(0, 99) >= IDLE_PCT)) begin
                    px = pending_pixels.pop_front();
                    push       <= 1'b1;
                    i_in_red   <= px.r;
                    i_in_green <= px.g;
                    i_in_blue  <= px.b;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // result side: compare each transfer, with one long hold-off
    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: result with no pixel outstanding", $time);
                    mismatch_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("pix_red", want.red, o_pix_red);
                    check_field("pix_green", want.green, o_pix_green);
                    check_field("pix_blue", want.blue, o_pix_blue);
                    check_field("frame_last", want.frame_last, o_frame_last);
                    check_field("blue_best_x", want.blue_best.x, o_blue_best_x);
                    check_field("blue_best_y", want.blue_best.y, o_blue_best_y);
                    check_field("blue_best_width", want.blue_best.width, o_blue_best_width);
                    check_field("red_best_x", want.red_best.x, o_red_best_x);
                    check_field("red_best_y", want.red_best.y, o_red_best_y);
                    check_field("red_best_width", want.red_best.width, o_red_best_width);
                end
                pixels_checked++;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (!hold_done && pixels_checked == HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                pop <= 1'b0;
            end else begin
                pop <= (pixels_checked >= CALM_FROM && pixels_checked < CALM_TO) ||
                       $urandom_range(0, 99) >= IDLE_PCT;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) stall_cycles <= 0;
            else stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corner pixels, threshold edges and wrapped differences
        configure(1, 4, 0, 65535);
        @(negedge i_clk);
        foreach (EDGE_PIXELS[i]) pending_pixels.push_back(EDGE_PIXELS[i]);

        // three samples per row, small frames so the best records reload often
        configure(51, 3, 0, 0);
        queue_pixels(250);
        // zero dimensions act as one pixel frames
        configure(0, 0, 65535, 65535);
        queue_pixels(30);
        configure(76, 2048, 0, 25);
        queue_pixels(140);
        // shrink both dimensions mid-frame
        configure(30, 1, 0, 0);
        queue_pixels(60);
        // oversized dimensions saturate
        configure(4095, 4095, 0, 0);
        queue_pixels(60);
        configure(126, 5, 1, 1);
        queue_pixels(130);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
